### rtl/utf8sd_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
package utf8sd_pkg;

    localparam int OFFSET_BITS_DEFAULT = 32;
    localparam int OUT_OFFSET_W        = 32;
    localparam int CP_W                = 21;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OVERLONG   = 2'd1,
        ST_INVALID    = 2'd2,
        ST_INCOMPLETE = 2'd3
    } status_t;

    // Lead and continuation byte classification
    localparam logic [7:0] MASK_ONE   = 8'h80;
    localparam logic [7:0] MASK_TWO   = 8'hE0;
    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] MASK_THREE = 8'hF0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] MASK_FOUR  = 8'hF8;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] TAG_CONT   = 8'h80;

    // Largest value that a shorter form could carry, per continuation count
    localparam logic [CP_W-1:0] LIMIT_TWO   = 21'd127;
    localparam logic [CP_W-1:0] LIMIT_THREE = 21'd2047;
    localparam logic [CP_W-1:0] LIMIT_FOUR  = 21'd65535;

endpackage

### rtl/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder: byte classification, sequence state, result register.
//
// Decodes a UTF-8 byte stream, one word (one byte plus an end-of-stream flag) per clock.
// Sequences of one to four bytes produce at most one result each: the code point with its
// start offset and status ok or overlong, an invalid byte with the byte and its own offset,
// or an incomplete sequence reported at its start when the stream ends inside it. After a
// bad continuation byte the rest of that sequence is swallowed unchecked. A word marked
// end_of_stream returns all state to reset, so the next word opens a new stream at offset 0.
// Throughput is one word per cycle: the decode is a short combinational
// path from the input port into the result register, and a new word is taken whenever
// the result register is empty or being drained in the same cycle. Offsets count in
// OFFSET_BITS bits and wrap; byte_offset carries their low 32 bits. Surrogates and values
// above 0x10FFFF are not checked.
module utf8_stream_decoder_unit #(
    parameter int OFFSET_BITS = utf8sd_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] code_point,
    output logic [1:0]  status,
    output logic [7:0]  bad_byte,
    output logic [31:0] byte_offset
);

    localparam int OW = utf8sd_pkg::OUT_OFFSET_W;
    localparam int CW = utf8sd_pkg::CP_W;

    // Sequence state
    logic [1:0]             pending_reg, pending_next;
    logic [1:0]             seq_len_reg, seq_len_next;
    logic [CW-1:0]          accum_reg, accum_next;
    logic [OFFSET_BITS-1:0] seq_start_reg, seq_start_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic                   error_reg, error_next;

    // Result register
    logic                   out_valid_reg, out_valid_next;
    logic [CW-1:0]          out_cp_reg;
    utf8sd_pkg::status_t    out_status_reg;
    logic [7:0]             out_bad_reg;
    logic [OW-1:0]          out_off_reg;

    // Decode results for the word on the port
    logic                   accept;
    logic                   emit;
    logic [CW-1:0]          res_cp;
    utf8sd_pkg::status_t    res_status;
    logic [7:0]             res_bad;
    logic                   res_at_start;
    logic [OW-1:0]          pos_off;
    logic [OW-1:0]          start_off;
    logic [1:0]             pending_dec;
    logic [CW-1:0]          accum_shift;
    logic [CW-1:0]          limit;
    logic                   is_cont;

    // Take a word whenever the result register is free or being emptied now
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Low 32 bits of the offsets, zero-extended for narrow counters
    generate
        if (OFFSET_BITS >= OW) begin : g_off_wide
            assign pos_off   = pos_reg[OW-1:0];
            assign start_off = seq_start_reg[OW-1:0];
        end else begin : g_off_narrow
            assign pos_off   = {{(OW-OFFSET_BITS){1'b0}}, pos_reg};
            assign start_off = {{(OW-OFFSET_BITS){1'b0}}, seq_start_reg};
        end
    endgenerate

    assign pending_dec = pending_reg - 2'd1;
    assign accum_shift = {accum_reg[CW-7:0], data_byte[5:0]};
    assign is_cont     = (data_byte & utf8sd_pkg::MASK_CONT) == utf8sd_pkg::TAG_CONT;

    always_comb
    begin
        case (seq_len_reg)
            2'd1:    limit = utf8sd_pkg::LIMIT_TWO;
            2'd2:    limit = utf8sd_pkg::LIMIT_THREE;
            default: limit = utf8sd_pkg::LIMIT_FOUR;
        endcase
    end

    always_comb
    begin
        pending_next   = pending_reg;
        seq_len_next   = seq_len_reg;
        accum_next     = accum_reg;
        seq_start_next = seq_start_reg;
        error_next     = error_reg;
        emit           = 1'b0;
        res_cp         = '0;
        res_status     = utf8sd_pkg::ST_OK;
        res_bad        = '0;
        res_at_start   = 1'b0;

        if (pending_reg == 2'd0) begin
            // Expect a lead byte
            if ((data_byte & utf8sd_pkg::MASK_ONE) == 8'h00) begin
                emit   = 1'b1;
                res_cp = {{(CW-8){1'b0}}, data_byte};
            end else if ((data_byte & utf8sd_pkg::MASK_TWO) == utf8sd_pkg::LEAD_TWO) begin
                pending_next = 2'd1;
                accum_next   = {{(CW-5){1'b0}}, data_byte[4:0]};
            end else if ((data_byte & utf8sd_pkg::MASK_THREE) == utf8sd_pkg::LEAD_THREE) begin
                pending_next = 2'd2;
                accum_next   = {{(CW-4){1'b0}}, data_byte[3:0]};
            end else if ((data_byte & utf8sd_pkg::MASK_FOUR) == utf8sd_pkg::LEAD_FOUR) begin
                pending_next = 2'd3;
                accum_next   = {{(CW-3){1'b0}}, data_byte[2:0]};
            end else begin
                emit       = 1'b1;
                res_status = utf8sd_pkg::ST_INVALID;
                res_bad    = data_byte;
            end
            if (pending_next != 2'd0) begin
                seq_len_next   = pending_next;
                seq_start_next = pos_reg;
                error_next     = 1'b0;
                if (end_of_stream) begin
                    // Truncated at the lead itself: report at this offset
                    emit       = 1'b1;
                    res_status = utf8sd_pkg::ST_INCOMPLETE;
                end
            end
        end else if (error_reg) begin
            // Swallow the rest of a broken sequence
            pending_next = pending_dec;
            if (pending_dec == 2'd0) begin
                error_next = 1'b0;
            end
        end else if (!is_cont) begin
            emit         = 1'b1;
            res_status   = utf8sd_pkg::ST_INVALID;
            res_bad      = data_byte;
            pending_next = pending_dec;
            error_next   = pending_dec != 2'd0;
        end else begin
            accum_next   = accum_shift;
            pending_next = pending_dec;
            if (pending_dec == 2'd0) begin
                emit         = 1'b1;
                res_cp       = accum_shift;
                res_at_start = 1'b1;
                res_status   = (accum_shift <= limit) ? utf8sd_pkg::ST_OVERLONG
                                                      : utf8sd_pkg::ST_OK;
            end else if (end_of_stream) begin
                emit         = 1'b1;
                res_at_start = 1'b1;
                res_status   = utf8sd_pkg::ST_INCOMPLETE;
            end
        end

        // End of stream: drop all state, next word starts at offset 0
        if (end_of_stream) begin
            pending_next   = '0;
            seq_len_next   = '0;
            accum_next     = '0;
            seq_start_next = '0;
            error_next     = 1'b0;
            pos_next       = '0;
        end else begin
            pos_next       = pos_reg + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
        end
    end

    always_comb
    begin
        if (accept) begin
            out_valid_next = emit;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_reg   <= '0;
            seq_len_reg   <= '0;
            accum_reg     <= '0;
            seq_start_reg <= '0;
            pos_reg       <= '0;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                pending_reg   <= pending_next;
                seq_len_reg   <= seq_len_next;
                accum_reg     <= accum_next;
                seq_start_reg <= seq_start_next;
                pos_reg       <= pos_next;
                error_reg     <= error_next;
            end
        end
    end

    // Result payload: load only when a word produces a result
    always_ff @(posedge clk)
    begin
        if (accept && emit) begin
            out_cp_reg     <= res_cp;
            out_status_reg <= res_status;
            out_bad_reg    <= res_bad;
            out_off_reg    <= res_at_start ? start_off : pos_off;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_point  = out_cp_reg;
    assign status      = out_status_reg;
    assign bad_byte    = out_bad_reg;
    assign byte_offset = out_off_reg;

`ifndef NO_ASSERTIONS
    // Swallowing only happens inside an open sequence
    a_error_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |-> pending_reg != 2'd0)
        else $error("error flag set with no sequence open");

    // Bytes still expected never exceed the sequence length
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= seq_len_reg)
        else $error("pending count above sequence length");

    // End of stream returns the decoder to its starting state
    a_eos_reset: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_stream |=> pos_reg == '0 && pending_reg == 2'd0 && !error_reg)
        else $error("state not cleared after end of stream");

    // Invalid results carry no code point
    a_invalid_cp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == utf8sd_pkg::ST_INVALID |-> code_point == '0)
        else $error("invalid result with non-zero code point");

    // Decoded results carry no bad byte
    a_decoded_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == utf8sd_pkg::ST_OK || status == utf8sd_pkg::ST_OVERLONG)
        |-> bad_byte == 8'h00)
        else $error("decoded result with non-zero bad byte");
`endif

endmodule
